### src/mwfb_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU
// write-request frame builder. No dependencies.
package mwfb_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned ByteIdxW   = $clog2(FrameBytes);
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0]  FuncWriteSingle = 8'h06;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [7:0]  StationReset    = 8'd5;

  // Frame byte positions, in transmission order
  localparam logic [ByteIdxW-1:0] ByteStation = 3'd0;
  localparam logic [ByteIdxW-1:0] ByteFunc    = 3'd1;
  localparam logic [ByteIdxW-1:0] ByteAddrHi  = 3'd2;
  localparam logic [ByteIdxW-1:0] ByteAddrLo  = 3'd3;
  localparam logic [ByteIdxW-1:0] ByteValHi   = 3'd4;
  localparam logic [ByteIdxW-1:0] ByteValLo   = 3'd5;
  localparam logic [ByteIdxW-1:0] ByteCrcLo   = 3'd6;
  localparam logic [ByteIdxW-1:0] ByteCrcHi   = 3'd7;

  // Configuration register indexes
  localparam logic RegStation = 1'b0;

  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] addr;
    logic [15:0] value;
  } request_t;

  // One byte through the reflected CRC-16 shift register
  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mwfb_front.sv
// Front stage: accepts write requests and tags them with the station address.
// Depends on mwfb_pkg.
module mwfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [15:0]         register_address_i,
  input  logic [15:0]         register_value_i,
  input  logic [7:0]          station_i,
  output logic                push_o,
  output mwfb_pkg::request_t  push_req_o,
  input  logic                q_full_i
);
  import mwfb_pkg::*;

  logic     valid_d, valid_q;
  request_t req_q;
  logic     accept;

  assign push_o     = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_req_o = req_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= '{station: station_i, addr: register_address_i, value: register_value_i};
    end
  end

endmodule

### src/mwfb_queue.sv
// Small request queue between the front and back stages.
// Depends on mwfb_pkg.
module mwfb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mwfb_pkg::request_t  push_req_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output mwfb_pkg::request_t  head_req_o
);
  import mwfb_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QueueDepth);

  request_t          entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [CntW-1:0]   count_d, count_q;

  assign full_o       = (count_q == DepthCnt);
  assign head_valid_o = (count_q != '0);
  assign head_req_o   = entry_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full queue");

endmodule

### src/mwfb_back.sv
// Back stage: serializes one request into eight frame bytes, folding the
// CRC-16 in one byte per cycle unless stalled. Depends on mwfb_pkg.
module mwfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  mwfb_pkg::request_t  q_req_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          frame_byte_o,
  output logic                last_byte_o
);
  import mwfb_pkg::*;

  logic                busy_d, busy_q;
  logic [ByteIdxW-1:0] idx_d, idx_q;
  logic [15:0]         crc_d, crc_q;
  request_t            req_q;
  logic                out_valid_d, out_valid_q;
  logic [7:0]          out_byte_q;
  logic                out_last_q;
  logic [7:0]          byte_sel;
  logic                out_free, emit, done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign done     = emit && (idx_q == ByteCrcHi);
  assign pop_o    = q_valid_i && (!busy_q || done);

  always_comb begin
    case (idx_q)
      ByteStation: byte_sel = req_q.station;
      ByteFunc:    byte_sel = FuncWriteSingle;
      ByteAddrHi:  byte_sel = req_q.addr[15:8];
      ByteAddrLo:  byte_sel = req_q.addr[7:0];
      ByteValHi:   byte_sel = req_q.value[15:8];
      ByteValLo:   byte_sel = req_q.value[7:0];
      ByteCrcLo:   byte_sel = crc_q[7:0];
      default:     byte_sel = crc_q[15:8];
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
      idx_d       = idx_q + 1'b1;
      if (idx_q < ByteCrcLo) begin
        crc_d = crc_byte(crc_q, byte_sel);
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
      crc_d  = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (pop_o) begin
      req_q <= q_req_i;
    end
    if (emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= (idx_q == ByteCrcHi);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_q |-> idx_q == '0)
    else $error("byte index not at frame start while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |=> out_valid_q && out_last_q)
    else $error("last frame byte not marked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !done) |=> out_valid_q && !out_last_q && busy_q)
    else $error("frame ended before its eighth byte");

endmodule

### src/modbus_write_frame_builder.sv
// Modbus RTU write-single-register request builder, top level.
// Path to the first frame byte: front register, queue, back-stage registers.
// Throughput: one byte per cycle out of the back-stage output register
// unless out_stall_i is high; the input takes beats while a frame drains.
// Reset: queue and serializer empty, station address set to 5.
// Depends on mwfb_pkg, mwfb_front, mwfb_queue, mwfb_back.
module modbus_write_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] register_address_i,
  input  logic [15:0] register_value_i,
  // frame byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mwfb_pkg::*;

  logic [7:0] station_q;
  logic       reg_sel;
  logic       cfg_write;

  logic       push;
  request_t   push_req;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  request_t   head_req;

  // Register index is the word address; anything past the station register
  // reads as zero and drops writes.
  assign reg_sel   = paddr[2];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (reg_sel == RegStation);
  assign prdata    = (reg_sel == RegStation) ? {24'h000000, station_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= StationReset;
    end else if (cfg_write) begin
      station_q <= pwdata[7:0];
    end
  end

  // Front: register the request and attach the station address
  mwfb_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .register_address_i (register_address_i),
    .register_value_i   (register_value_i),
    .station_i          (station_q),
    .push_o             (push),
    .push_req_o         (push_req),
    .q_full_i           (q_full)
  );

  // Queue: decouple the request side from the byte serializer
  mwfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (push_req),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_req_o   (head_req)
  );

  // Back: emit eight bytes per request, CRC computed as bytes go out
  mwfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (head_valid),
    .q_req_i      (head_req),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule
